// ----- sv/duplex_matrix_scan_with_stick_keys_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the duplex matrix scanner
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUPLEX_MATRIX_SCAN_WITH_STICK_KEYS_MACROS_SVH
`define DUPLEX_MATRIX_SCAN_WITH_STICK_KEYS_MACROS_SVH

// Same-cycle implication
`define DMSK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DMSK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dmsk_pkg.sv -----
// ----------------------------------------------------------------------------
// dmsk_pkg
// Types and fixed constants of the duplex key matrix scanner.
// ----------------------------------------------------------------------------
package dmsk_pkg;

  localparam int ROW_LINES    = 4;
  localparam int COLUMN_LINES = 5;
  localparam int STROBE_LINES = ROW_LINES + COLUMN_LINES;
  localparam int MATRIX_ROWS  = 2 * ROW_LINES;
  localparam int MATRIX_BITS  = MATRIX_ROWS * COLUMN_LINES;
  localparam int IDX_W        = 4;
  localparam int AXIS_W       = 10;
  localparam int SETTLE_W     = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Stick key positions inside the matrix
  localparam int BIT_UP    = 35;
  localparam int BIT_DOWN  = 8;
  localparam int BIT_LEFT  = 18;
  localparam int BIT_RIGHT = 13;

  localparam logic [MATRIX_BITS-1:0] KEPT_MASK =
    (MATRIX_BITS'(1) << BIT_UP) | (MATRIX_BITS'(1) << BIT_DOWN) |
    (MATRIX_BITS'(1) << BIT_LEFT) | (MATRIX_BITS'(1) << BIT_RIGHT);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS   = 3'd3;

  // Configuration reset values
  localparam logic [AXIS_W-1:0]   THRESHOLD_HIGH_RST = 10'd800;
  localparam logic [AXIS_W-1:0]   THRESHOLD_LOW_RST  = 10'd200;
  localparam logic [AXIS_W-1:0]   HYSTERESIS_RST     = 10'd50;
  localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST   = 16'd30;

  // Per-tick control from the strobe sequencer
  typedef struct packed {
    logic [ROW_LINES-1:0]    row_drive;
    logic [COLUMN_LINES-1:0] column_drive;
    logic                    sample;
    logic                    frame_end;
    logic [IDX_W-1:0]        idx;
  } seq_ctl_t;

  // One result transaction
  typedef struct packed {
    logic [ROW_LINES-1:0]    row_drive;
    logic [COLUMN_LINES-1:0] column_drive;
    logic [MATRIX_BITS-1:0]  key_matrix;
    logic                    frame_done;
    logic                    matrix_changed;
  } result_t;

endpackage

// ----- sv/dmsk_seq.sv -----
// ----------------------------------------------------------------------------
// dmsk_seq
// Strobe sequencer: walks rows then columns, drive and release phases.
// ----------------------------------------------------------------------------
module dmsk_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [dmsk_pkg::SETTLE_W-1:0] settle_ticks,
  output dmsk_pkg::seq_ctl_t            ctl
);

  localparam logic [1:0] PH_DRIVE   = 2'd0;
  localparam logic [1:0] PH_RELEASE = 2'd1;
  localparam logic [dmsk_pkg::IDX_W-1:0] IDX_LAST =
    dmsk_pkg::IDX_W'(dmsk_pkg::STROBE_LINES - 1);
  localparam logic [dmsk_pkg::IDX_W-1:0] IDX_ROWS =
    dmsk_pkg::IDX_W'(dmsk_pkg::ROW_LINES);

  logic [dmsk_pkg::IDX_W-1:0]    idx_r, idx_nxt, idx_eff;
  logic [1:0]                    phase_r, phase_nxt;
  logic [dmsk_pkg::SETTLE_W-1:0] cnt_r, cnt_nxt, cnt_inc, need;
  logic                          hit;
  logic [dmsk_pkg::IDX_W-1:0]    col_idx;

  // Phase length; zero acts as one
  assign need    = (settle_ticks == '0) ? dmsk_pkg::SETTLE_W'(1) : settle_ticks;
  assign cnt_inc = cnt_r + dmsk_pkg::SETTLE_W'(1);
  assign hit     = (cnt_inc >= need);
  assign idx_eff = (idx_r > IDX_LAST) ? '0 : idx_r;
  assign col_idx = idx_eff - IDX_ROWS;

  // Next state and tick control
  always_comb begin
    idx_nxt          = idx_eff;
    phase_nxt        = phase_r;
    cnt_nxt          = cnt_inc;
    ctl.row_drive    = '0;
    ctl.column_drive = '0;
    ctl.sample       = 1'b0;
    ctl.frame_end    = 1'b0;
    ctl.idx          = idx_eff;
    case (phase_r)
      PH_DRIVE: begin
        if (idx_eff < IDX_ROWS) begin
          ctl.row_drive = dmsk_pkg::ROW_LINES'(1) << idx_eff[1:0];
        end else begin
          ctl.column_drive = dmsk_pkg::COLUMN_LINES'(1) << col_idx[2:0];
        end
        if (hit) begin
          ctl.sample = 1'b1;
          cnt_nxt    = '0;
          phase_nxt  = PH_RELEASE;
        end
      end
      default: begin
        if (hit) begin
          cnt_nxt   = '0;
          phase_nxt = PH_DRIVE;
          if (idx_eff == IDX_LAST) begin
            ctl.frame_end = 1'b1;
            idx_nxt       = '0;
          end else begin
            idx_nxt = idx_eff + dmsk_pkg::IDX_W'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      phase_r <= PH_DRIVE;
      cnt_r   <= '0;
    end else if (step) begin
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- sv/dmsk_keys.sv -----
// ----------------------------------------------------------------------------
// dmsk_keys
// Key bit store: strobe sampling, stick hysteresis and frame change flag.
// ----------------------------------------------------------------------------
module dmsk_keys (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  dmsk_pkg::seq_ctl_t                  ctl,
  input  logic [dmsk_pkg::COLUMN_LINES-1:0]   column_levels,
  input  logic [dmsk_pkg::ROW_LINES-1:0]      row_levels,
  input  logic [dmsk_pkg::AXIS_W-1:0]         stick_y,
  input  logic [dmsk_pkg::AXIS_W-1:0]         stick_x,
  input  logic [dmsk_pkg::AXIS_W-1:0]         threshold_high,
  input  logic [dmsk_pkg::AXIS_W-1:0]         threshold_low,
  input  logic [dmsk_pkg::AXIS_W-1:0]         hysteresis,
  output logic [dmsk_pkg::MATRIX_BITS-1:0]    key_matrix,
  output logic                                frame_changed
);

  logic [dmsk_pkg::MATRIX_BITS-1:0] key_r, key_nxt, wr_mask, wr_val, sampled;
  logic                             seen_r, seen_nxt, tick_change;
  logic signed [dmsk_pkg::AXIS_W+1:0] rel_high, y_s, x_s;
  logic [dmsk_pkg::AXIS_W:0]          rel_low;
  logic up_on, up_off, dn_on, dn_off, lf_on, lf_off, rt_on, rt_off;

  // Write mask of the strobe being sampled, stick positions excluded
  always_comb begin
    wr_mask = '0;
    wr_val  = '0;
    for (int r = 0; r < dmsk_pkg::MATRIX_ROWS; r++) begin
      for (int c = 0; c < dmsk_pkg::COLUMN_LINES; c++) begin
        if (r < dmsk_pkg::ROW_LINES) begin
          wr_mask[r*dmsk_pkg::COLUMN_LINES+c] =
            (ctl.idx == dmsk_pkg::IDX_W'(r));
          wr_val[r*dmsk_pkg::COLUMN_LINES+c] = column_levels[c];
        end else begin
          wr_mask[r*dmsk_pkg::COLUMN_LINES+c] =
            (ctl.idx == dmsk_pkg::IDX_W'(dmsk_pkg::ROW_LINES + c));
          wr_val[r*dmsk_pkg::COLUMN_LINES+c] = row_levels[r-dmsk_pkg::ROW_LINES];
        end
      end
    end
    wr_mask = wr_mask & ~dmsk_pkg::KEPT_MASK & {dmsk_pkg::MATRIX_BITS{ctl.sample}};
  end

  assign sampled = (key_r & ~wr_mask) | (wr_val & wr_mask);

  // Release levels, no wrap on the high side
  assign rel_high = $signed({2'b00, threshold_high}) - $signed({2'b00, hysteresis});
  assign rel_low  = {1'b0, threshold_low} + {1'b0, hysteresis};
  assign y_s      = $signed({2'b00, stick_y});
  assign x_s      = $signed({2'b00, stick_x});

  assign up_on  = stick_y > threshold_high;
  assign up_off = y_s < rel_high;
  assign dn_on  = stick_y < threshold_low;
  assign dn_off = {1'b0, stick_y} > rel_low;
  assign lf_on  = stick_x > threshold_high;
  assign lf_off = x_s < rel_high;
  assign rt_on  = stick_x < threshold_low;
  assign rt_off = {1'b0, stick_x} > rel_low;

  // Stick keys update only at frame end; set wins over clear
  always_comb begin
    key_nxt = sampled;
    if (ctl.frame_end) begin
      if (up_on) key_nxt[dmsk_pkg::BIT_UP] = 1'b1;
      else if (up_off) key_nxt[dmsk_pkg::BIT_UP] = 1'b0;
      if (dn_on) key_nxt[dmsk_pkg::BIT_DOWN] = 1'b1;
      else if (dn_off) key_nxt[dmsk_pkg::BIT_DOWN] = 1'b0;
      if (lf_on) key_nxt[dmsk_pkg::BIT_LEFT] = 1'b1;
      else if (lf_off) key_nxt[dmsk_pkg::BIT_LEFT] = 1'b0;
      if (rt_on) key_nxt[dmsk_pkg::BIT_RIGHT] = 1'b1;
      else if (rt_off) key_nxt[dmsk_pkg::BIT_RIGHT] = 1'b0;
    end
  end

  // Change tracking across the frame
  assign tick_change   = (key_nxt != key_r);
  assign frame_changed = seen_r | tick_change;
  assign seen_nxt      = ctl.frame_end ? 1'b0 : frame_changed;
  assign key_matrix    = key_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      seen_r <= 1'b0;
    end else if (step) begin
      key_r  <= key_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

// ----- sv/duplex_matrix_scan_with_stick_keys.sv -----
// Path: an accepted tick is held in the input register, then goes through the
//   scan/key logic into the result register.
// Throughput: one tick per cycle while in_stall is low; a two-entry result
//   buffer absorbs an output stall, and in_stall rises once the skid slot fills.
// Reset: synchronous active-low rst_n clears keys, sequencer and valids and
//   loads threshold_high 800, threshold_low 200, hysteresis 50, settle_ticks 30.
// ----------------------------------------------------------------------------
// duplex_matrix_scan_with_stick_keys
// Duplex key matrix scanner with analog stick keys and frame change report.
// ----------------------------------------------------------------------------
`include "duplex_matrix_scan_with_stick_keys_macros.svh"

module duplex_matrix_scan_with_stick_keys (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [dmsk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmsk_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // tick input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dmsk_pkg::COLUMN_LINES-1:0]   in_column_levels,
  input  logic [dmsk_pkg::ROW_LINES-1:0]      in_row_levels,
  input  logic [dmsk_pkg::AXIS_W-1:0]         in_stick_y,
  input  logic [dmsk_pkg::AXIS_W-1:0]         in_stick_x,
  // result
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dmsk_pkg::ROW_LINES-1:0]      out_row_drive,
  output logic [dmsk_pkg::COLUMN_LINES-1:0]   out_column_drive,
  output logic [dmsk_pkg::MATRIX_BITS-1:0]    out_key_matrix,
  output logic                                out_frame_done,
  output logic                                out_matrix_changed
);

  logic [dmsk_pkg::AXIS_W-1:0]       thr_high_r, thr_low_r, hyst_r;
  logic [dmsk_pkg::SETTLE_W-1:0]     settle_r;

  logic                              in_v_r;
  logic [dmsk_pkg::COLUMN_LINES-1:0] cols_r;
  logic [dmsk_pkg::ROW_LINES-1:0]    rows_r;
  logic [dmsk_pkg::AXIS_W-1:0]       y_r, x_r;

  logic                              in_take, fire, out_take;
  dmsk_pkg::seq_ctl_t                ctl;
  dmsk_pkg::result_t                 res, out_r, skid_r;
  logic                              out_v_r, skid_v_r;
  logic [dmsk_pkg::MATRIX_BITS-1:0]  key_matrix;
  logic                              frame_changed;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_high_r <= dmsk_pkg::THRESHOLD_HIGH_RST;
      thr_low_r  <= dmsk_pkg::THRESHOLD_LOW_RST;
      hyst_r     <= dmsk_pkg::HYSTERESIS_RST;
      settle_r   <= dmsk_pkg::SETTLE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dmsk_pkg::REG_THRESHOLD_HIGH: thr_high_r <= cfg_wdata[dmsk_pkg::AXIS_W-1:0];
        dmsk_pkg::REG_THRESHOLD_LOW:  thr_low_r  <= cfg_wdata[dmsk_pkg::AXIS_W-1:0];
        dmsk_pkg::REG_HYSTERESIS:     hyst_r     <= cfg_wdata[dmsk_pkg::AXIS_W-1:0];
        dmsk_pkg::REG_SETTLE_TICKS:   settle_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the input stage fires when it holds a tick and the skid slot is free
  assign fire     = in_v_r & ~skid_v_r;
  assign in_stall = in_v_r & skid_v_r;
  assign in_take  = in_valid & ~in_stall;
  assign out_take = out_v_r & ~out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take || fire) begin
      in_v_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cols_r <= in_column_levels;
      rows_r <= in_row_levels;
      y_r    <= in_stick_y;
      x_r    <= in_stick_x;
    end
  end

  dmsk_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (fire),
    .settle_ticks (settle_r),
    .ctl          (ctl)
  );

  dmsk_keys u_keys (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (fire),
    .ctl            (ctl),
    .column_levels  (cols_r),
    .row_levels     (rows_r),
    .stick_y        (y_r),
    .stick_x        (x_r),
    .threshold_high (thr_high_r),
    .threshold_low  (thr_low_r),
    .hysteresis     (hyst_r),
    .key_matrix     (key_matrix),
    .frame_changed  (frame_changed)
  );

  // Result of this tick
  always_comb begin
    res.row_drive      = ctl.row_drive;
    res.column_drive   = ctl.column_drive;
    res.key_matrix     = key_matrix;
    res.frame_done     = ctl.frame_end;
    res.matrix_changed = ctl.frame_end & frame_changed;
  end

  // Result register plus skid slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_take) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end else begin
          out_v_r <= fire;
        end
      end else if (fire) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_take) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (fire) begin
        out_r <= res;
      end
    end else if (fire) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_row_drive      = out_r.row_drive;
  assign out_column_drive   = out_r.column_drive;
  assign out_key_matrix     = out_r.key_matrix;
  assign out_frame_done     = out_r.frame_done;
  assign out_matrix_changed = out_r.matrix_changed;

  // Checks
  `DMSK_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r, "skid entry without result")
  `DMSK_ASSERT_IMP(a_one_strobe, out_v_r,
    !((|out_r.row_drive) && (|out_r.column_drive)) && $onehot0(out_r.row_drive)
    && $onehot0(out_r.column_drive), "more than one strobe line driven")
  `DMSK_ASSERT_IMP(a_done_released, out_v_r && out_r.frame_done,
    out_r.row_drive == '0 && out_r.column_drive == '0, "frame end while driving")
  `DMSK_ASSERT_NXT(a_kept_hold, fire && !ctl.frame_end,
    (u_keys.key_r & dmsk_pkg::KEPT_MASK) == ($past(u_keys.key_r) & dmsk_pkg::KEPT_MASK),
    "stick key changed outside frame end")

endmodule
